[hdl/mfd_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, defaults and control types of the most frequent date finder.
package mfd_pkg;

   // Date field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DATE_W  = DAY_W + MONTH_W + YEAR_W;

   // Reported count width; larger counts saturate
   localparam int MODE_CNT_W = 5;
   localparam int MODE_CNT_MAX = 31;

   // Default store depth
   localparam int MAX_ENTRIES_DEF = 16;

   // Sequencer to tally unit controls
   typedef struct packed {
      logic key_load;   // read data is the next key; clear hit count
      logic scan;       // read data is a store entry to compare with the key
      logic scan_last;  // last entry of this key's scan
      logic first_key;  // key is store entry 0
   } tally_ctl_type;

endpackage

[hdl/mfd_ram.sv]
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
module mfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/mfd_tally.sv]
`timescale 1ns / 1ps
// Shared compare and count unit: counts matches of one key, keeps the best key.
module mfd_tally
   import mfd_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  tally_ctl_type     ctl,
   input  logic [DATE_W-1:0] rd_data,
   output logic [DATE_W-1:0] best_date,
   output logic [CNT_W-1:0]  best_cnt
);

   logic [DATE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  hits_ff, hits_in;
   logic [DATE_W-1:0] best_date_ff, best_date_in;
   logic [CNT_W-1:0]  best_cnt_ff, best_cnt_in;
   logic              match;
   logic [CNT_W-1:0]  hits_now;

   // One equality compare and one increment per cycle
   assign match    = (rd_data == key_ff);
   assign hits_now = hits_ff + CNT_W'(match);

   // Later keys replace the best only on a strictly greater count
   always_comb begin
      key_in       = key_ff;
      hits_in      = hits_ff;
      best_date_in = best_date_ff;
      best_cnt_in  = best_cnt_ff;
      if (ctl.key_load) begin
         key_in  = rd_data;
         hits_in = '0;
      end else if (ctl.scan) begin
         hits_in = hits_now;
         if (ctl.scan_last && (ctl.first_key || (hits_now > best_cnt_ff))) begin
            best_date_in = key_ff;
            best_cnt_in  = hits_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      hits_ff      <= hits_in;
      best_date_ff <= best_date_in;
      best_cnt_ff  <= best_cnt_in;
   end

   assign best_date = best_date_ff;
   assign best_cnt  = best_cnt_ff;

endmodule

[hdl/mfd_seq.sv]
`timescale 1ns / 1ps
// Sequencer: stores entries, walks key and scan indexes, flags the result.
module mfd_seq
   import mfd_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             last_entry,
   output logic             busy,
   output logic             rsp_valid,
   output logic             overflow,
   output logic             we,
   output logic [IDX_W-1:0] waddr,
   output logic [IDX_W-1:0] raddr,
   output tally_ctl_type    ctl
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_KEY_RD = 3'd1;
   localparam logic [2:0] ST_KEY_LD = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] last_idx;
   logic             accept;
   logic             room;

   assign accept   = start && (state_ff == ST_IDLE);
   assign room     = (count_ff < CNT_W'(MAX_ENTRIES));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign waddr    = count_ff[IDX_W-1:0];

   // Next state and datapath control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      we       = 1'b0;
      raddr    = i_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  we       = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (last_entry) begin
                  i_in     = '0;
                  state_in = ST_KEY_RD;
               end
            end
         end
         ST_KEY_RD: begin
            raddr    = i_ff;
            state_in = ST_KEY_LD;
         end
         ST_KEY_LD: begin
            ctl.key_load = 1'b1;
            raddr        = '0;
            j_in         = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            ctl.scan      = 1'b1;
            ctl.first_key = (i_ff == '0);
            ctl.scan_last = (j_ff == last_idx);
            if (j_ff != last_idx) begin
               j_in  = j_ff + IDX_W'(1);
               raddr = j_ff + IDX_W'(1);
            end else if (i_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               raddr    = i_ff + IDX_W'(1);
               state_in = ST_KEY_LD;
            end
         end
         ST_DONE: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign overflow  = ovf_ff;

   // Store fill never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond store depth");

   // Computation only runs over a non-empty store
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KEY_RD) |-> (count_ff != '0))
      else $error("count started on an empty store");

   // Scan index stays within the stored entries
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((j_ff <= last_idx) && (i_ff <= last_idx)))
      else $error("scan index past last stored entry");

   // A result leaves the block cleared for the next list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> ((count_ff == '0) && !ovf_ff && !busy))
      else $error("list state not cleared after result");

endmodule

[hdl/most_frequent_date_finder.sv]
`timescale 1ns / 1ps
// Top level of the most frequent date finder.
//
//   channel   ports                          handshake
//   request   req_entry_*, req_last_entry    taken when start && !busy
//   response  rsp_mode_*, rsp_overflow_seen  one-cycle strobe rsp_valid
//
// An entry without the last marker is stored (or flagged as overflow); busy stays low.
// The last entry starts the count, done by one shared compare/count unit
// reading the store one entry a cycle.
// busy stays high until the cycle that carries rsp_valid has passed.
// Reset is synchronous and clears the list; store contents need no reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module most_frequent_date_finder
   import mfd_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [DAY_W-1:0]   req_entry_day,
   input  logic [MONTH_W-1:0] req_entry_month,
   input  logic [YEAR_W-1:0]  req_entry_year,
   input  logic               req_last_entry,
   output logic               rsp_valid,
   output logic [DAY_W-1:0]   rsp_mode_day,
   output logic [MONTH_W-1:0] rsp_mode_month,
   output logic [YEAR_W-1:0]  rsp_mode_year,
   output logic [MODE_CNT_W-1:0] rsp_mode_count,
   output logic               rsp_overflow_seen
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SAT_W = (CNT_W > MODE_CNT_W) ? CNT_W : MODE_CNT_W;

   logic              we;
   logic [IDX_W-1:0]  waddr;
   logic [IDX_W-1:0]  raddr;
   logic [DATE_W-1:0] wdata;
   logic [DATE_W-1:0] rdata;
   tally_ctl_type     ctl;
   logic [DATE_W-1:0] best_date;
   logic [CNT_W-1:0]  best_cnt;
   logic [SAT_W-1:0]  best_cnt_wide;

   // Packed date: day, month, year from high to low
   assign wdata = {req_entry_day, req_entry_month, req_entry_year};

   mfd_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_entry (req_last_entry),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .overflow   (rsp_overflow_seen),
      .we         (we),
      .waddr      (waddr),
      .raddr      (raddr),
      .ctl        (ctl)
   );

   mfd_ram #(
      .WIDTH (DATE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   mfd_tally #(
      .CNT_W (CNT_W)
   ) u_tally (
      .clock     (clock),
      .ctl       (ctl),
      .rd_data   (rdata),
      .best_date (best_date),
      .best_cnt  (best_cnt)
   );

   // Result fields, count saturated to the reported width
   assign best_cnt_wide  = SAT_W'(best_cnt);
   assign rsp_mode_count = (best_cnt_wide > SAT_W'(MODE_CNT_MAX)) ?
                           MODE_CNT_W'(MODE_CNT_MAX) : best_cnt_wide[MODE_CNT_W-1:0];
   assign rsp_mode_day   = best_date[DATE_W-1 -: DAY_W];
   assign rsp_mode_month = best_date[YEAR_W +: MONTH_W];
   assign rsp_mode_year  = best_date[YEAR_W-1:0];

endmodule
